@@ sv/djsc_pkg.sv @@
// Shared types, constants and helper functions of the differential joint step controller.
package djsc_pkg;

  localparam int COUNT_BITS   = 24;
  localparam int DUTY_BITS    = 8;
  localparam int STEP_BITS    = 16;
  localparam int BAND_BITS    = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int EXT_BITS     = COUNT_BITS + 2;

  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1004);
  localparam logic [BAND_BITS-1:0] BAND_RESET = BAND_BITS'(100);
  localparam logic [DUTY_BITS-1:0] DUTY_RESET = DUTY_BITS'(100);

  localparam logic signed [EXT_BITS-1:0] CNT_MAX =
    EXT_BITS'((64'sd1 <<< (COUNT_BITS - 1)) - 64'sd1);
  localparam logic signed [EXT_BITS-1:0] CNT_MIN =
    EXT_BITS'(-(64'sd1 <<< (COUNT_BITS - 1)));

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP     = 2'd0,
    CFG_DEADBAND = 2'd1,
    CFG_DUTY     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [STEP_BITS-1:0] step_counts;
    logic [BAND_BITS-1:0] deadband_counts;
    logic [DUTY_BITS-1:0] drive_duty;
  } cfg_t;

  typedef struct packed {
    logic                         action;
    logic [3:0]                   cmd_bits;
    logic signed [COUNT_BITS-1:0] encoder_count;
    logic                         limit_up_pressed;
    logic                         limit_down_pressed;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0]         duty;
    logic                         motor1_forward;
    logic                         motor2_forward;
    logic                         clear_encoder;
    logic                         up_limit_stop;
    logic                         down_limit_stop;
    logic signed [COUNT_BITS-1:0] reported_position;
  } out_item_t;

  function automatic logic signed [COUNT_BITS-1:0] sat_count(
    input logic signed [EXT_BITS-1:0] v
  );
    logic signed [EXT_BITS-1:0] r;
    if (v > CNT_MAX) begin
      r = CNT_MAX;
    end else if (v < CNT_MIN) begin
      r = CNT_MIN;
    end else begin
      r = v;
    end
    return $signed(r[COUNT_BITS-1:0]);
  endfunction

  function automatic logic needs_drive(
    input logic signed [COUNT_BITS-1:0] target,
    input logic signed [COUNT_BITS-1:0] pos,
    input logic                         negative,
    input logic [BAND_BITS-1:0]         deadband
  );
    logic signed [EXT_BITS-1:0] t;
    logic signed [EXT_BITS-1:0] p;
    logic signed [EXT_BITS-1:0] err;
    logic signed [EXT_BITS-1:0] db;
    t  = EXT_BITS'(target);
    p  = EXT_BITS'(pos);
    db = EXT_BITS'(deadband);
    err = negative ? (p - t) : (t - p);
    return err > db;
  endfunction

endpackage

@@ sv/djsc_cfg_regs.sv @@
// Configuration register file: step size, deadband and drive duty.
module djsc_cfg_regs
  import djsc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STEP:     cfg_d.step_counts     = cfg_data_i[STEP_BITS-1:0];
        CFG_DEADBAND: cfg_d.deadband_counts = cfg_data_i[BAND_BITS-1:0];
        CFG_DUTY:     cfg_d.drive_duty      = cfg_data_i[DUTY_BITS-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_counts     <= STEP_RESET;
      cfg_q.deadband_counts <= BAND_RESET;
      cfg_q.drive_duty      <= DUTY_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ sv/djsc_in_reg.sv @@
// Input register stage holding one accepted beat for the step logic.
module djsc_in_reg
  import djsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t data_o
);

  logic     valid_q, valid_d;
  in_item_t data_q, data_d;
  logic     load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_o    = valid_q;
  assign data_o     = data_q;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = in_data_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

@@ sv/djsc_core.sv @@
// Joint state registers and the per-beat command and tick logic.
module djsc_core
  import djsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  logic signed [COUNT_BITS-1:0] bevel_target_q, bevel_target_d;
  logic signed [COUNT_BITS-1:0] lift_target_q, lift_target_d;
  logic bevel_active_q, bevel_active_d;
  logic lift_active_q, lift_active_d;
  logic bevel_neg_q, bevel_neg_d;
  logic lift_neg_q, lift_neg_d;
  logic m1_q, m1_d;
  logic m2_q, m2_d;

  logic signed [EXT_BITS-1:0]   pos_ext;
  logic signed [EXT_BITS-1:0]   step_ext;
  logic signed [COUNT_BITS-1:0] tgt_plus;
  logic signed [COUNT_BITS-1:0] tgt_minus;
  logic signed [COUNT_BITS-1:0] pos;
  logic up_hit;
  logic down_hit;
  logic drive_bevel;
  logic drive_lift;

  assign pos_ext   = EXT_BITS'(item_i.encoder_count);
  assign step_ext  = EXT_BITS'(cfg_i.step_counts);
  assign tgt_plus  = sat_count(pos_ext + step_ext);
  assign tgt_minus = sat_count(pos_ext - step_ext);
  assign up_hit    = item_i.limit_up_pressed && lift_active_q && !lift_neg_q;
  assign down_hit  = item_i.limit_down_pressed && lift_active_q && lift_neg_q;

  always_comb begin
    bevel_target_d = bevel_target_q;
    lift_target_d  = lift_target_q;
    bevel_active_d = bevel_active_q;
    lift_active_d  = lift_active_q;
    bevel_neg_d    = bevel_neg_q;
    lift_neg_d     = lift_neg_q;
    m1_d           = m1_q;
    m2_d           = m2_q;
    pos            = item_i.encoder_count;
    drive_bevel    = 1'b0;
    drive_lift     = 1'b0;
    result_o       = '0;

    if (!item_i.action) begin
      bevel_active_d = 1'b0;
      lift_active_d  = 1'b0;
      if (item_i.cmd_bits[1]) begin
        bevel_target_d = tgt_minus;
        bevel_neg_d    = 1'b1;
        bevel_active_d = 1'b1;
      end else if (item_i.cmd_bits[0]) begin
        bevel_target_d = tgt_plus;
        bevel_neg_d    = 1'b0;
        bevel_active_d = 1'b1;
      end
      if (item_i.cmd_bits[3]) begin
        lift_target_d = tgt_minus;
        lift_neg_d    = 1'b1;
        lift_active_d = 1'b1;
      end else if (item_i.cmd_bits[2]) begin
        lift_target_d = tgt_plus;
        lift_neg_d    = 1'b0;
        lift_active_d = 1'b1;
      end
    end else begin
      if (up_hit) begin
        bevel_active_d = 1'b0;
        lift_active_d  = 1'b0;
        bevel_target_d = '0;
        lift_target_d  = '0;
        pos            = '0;
      end else if (down_hit) begin
        bevel_active_d = 1'b0;
        lift_active_d  = 1'b0;
      end
      drive_bevel = bevel_active_d &&
                    needs_drive(bevel_target_d, pos, bevel_neg_q, cfg_i.deadband_counts);
      drive_lift  = lift_active_d &&
                    needs_drive(lift_target_d, pos, lift_neg_q, cfg_i.deadband_counts);
      if (drive_lift) begin
        m1_d            = !lift_neg_q;
        m2_d            = lift_neg_q;
        result_o.duty   = cfg_i.drive_duty;
      end else if (drive_bevel) begin
        m1_d            = !bevel_neg_q;
        m2_d            = !bevel_neg_q;
        result_o.duty   = cfg_i.drive_duty;
      end
      result_o.clear_encoder   = up_hit;
      result_o.up_limit_stop   = up_hit;
      result_o.down_limit_stop = !up_hit && down_hit;
    end

    result_o.motor1_forward    = m1_d;
    result_o.motor2_forward    = m2_d;
    result_o.reported_position = pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bevel_target_q <= '0;
      lift_target_q  <= '0;
      bevel_active_q <= 1'b0;
      lift_active_q  <= 1'b0;
      bevel_neg_q    <= 1'b0;
      lift_neg_q     <= 1'b0;
      m1_q           <= 1'b0;
      m2_q           <= 1'b0;
    end else if (fire_i) begin
      bevel_target_q <= bevel_target_d;
      lift_target_q  <= lift_target_d;
      bevel_active_q <= bevel_active_d;
      lift_active_q  <= lift_active_d;
      bevel_neg_q    <= bevel_neg_d;
      lift_neg_q     <= lift_neg_d;
      m1_q           <= m1_d;
      m2_q           <= m2_d;
    end
  end

endmodule

@@ sv/djsc_out_reg.sv @@
// Result register stage driving the output channel.
module djsc_out_reg
  import djsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t data_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      valid_q, valid_d;
  out_item_t data_q, data_d;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = data_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

@@ sv/differential_joint_step_controller.sv @@
// Top level of the differential joint step controller.
// One input beat in, one result beat out. A command beat (action 0) sets a
// bevel and/or lift target one step from the carried encoder count; a tick
// beat (action 1) checks the limit switches and drives the motors at the
// configured duty while the signed remaining error exceeds the deadband,
// lift before bevel. An accepted beat is held in the input register,
// passes the step logic and lands in the result register; one beat per
// cycle is sustained while the output channel is not stalled by out_ready.
// Configuration writes take effect at once and belong to idle periods.
module differential_joint_step_controller
  import djsc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  stage_item;
  logic      stage_valid;
  logic      out_free;
  logic      fire;
  out_item_t result;

  assign fire = stage_valid && out_free;

  djsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  djsc_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (fire),
    .valid_o    (stage_valid),
    .data_o     (stage_item)
  );

  djsc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_item),
    .cfg_i    (cfg),
    .result_o (result)
  );

  djsc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .data_i      (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
